FILE: src/quad_motor_mixer_unit_defines.svh
// Assertion macros for the quad motor mixer unit.
// Depends on nothing; included by the top level only.
`ifndef QUAD_MOTOR_MIXER_UNIT_DEFINES_SVH
`define QUAD_MOTOR_MIXER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define QMM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");
`define QMM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define QMM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define QMM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/qmm_pkg.sv
// Widths, constants and item types of the quad motor mixer.
// Depends on nothing; imported by every module of the block except qmm_fifo.
package qmm_pkg;

    localparam int unsigned THR_W      = 10;
    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned DVS_W      = 16;
    localparam int unsigned SW_W       = 12;
    localparam int unsigned MOTOR_W    = 11;
    localparam int unsigned Q_FRAC     = 14;
    localparam int unsigned PROD_W     = 26;
    localparam int unsigned TERM_W     = 12;
    localparam int unsigned BASE_W     = THR_W + Q_FRAC;
    localparam int unsigned CMD_W      = BASE_W + 2;
    localparam int unsigned MAG_W      = BASE_W + 1;
    localparam int unsigned CEIL_W     = 10;
    localparam int unsigned SDIV_W     = MAG_W + CEIL_W;
    localparam int unsigned SQ_W       = 13;
    localparam int unsigned NUM_MOTORS = 4;

    localparam logic [SW_W-1:0]    ARM_THR_RST = 12'd1500;
    localparam logic [CEIL_W-1:0]  CMD_CEIL    = 10'd1000;
    localparam logic [MOTOR_W-1:0] MOTOR_IDLE  = 11'd1000;
    localparam logic [MOTOR_W-1:0] MOTOR_MAX   = 11'd2000;

    typedef struct packed {
        logic [THR_W-1:0]         throttle;
        logic signed [PROD_W-1:0] prod_roll;
        logic signed [PROD_W-1:0] prod_pitch;
        logic signed [PROD_W-1:0] prod_yaw;
        logic [DVS_W-1:0]         divisor;
        logic                     armed;
        logic                     leds_on;
    } t_mid_item;

    typedef struct packed {
        logic signed [TERM_W-1:0] term_roll;
        logic signed [TERM_W-1:0] term_pitch;
        logic signed [TERM_W-1:0] term_yaw;
        logic                     armed;
        logic                     leds_on;
    } t_side;

    typedef struct packed {
        logic [BASE_W-1:0] base;
        t_side             side;
    } t_mix_item;

    typedef struct packed {
        logic [MOTOR_W-1:0] motor_a;
        logic [MOTOR_W-1:0] motor_b;
        logic [MOTOR_W-1:0] motor_c;
        logic [MOTOR_W-1:0] motor_d;
        logic               armed;
        logic               leds_on;
        logic               scaled;
    } t_res_item;

endpackage

FILE: src/quad_motor_mixer_unit.sv
// Quad X-frame motor mixer: one command item in, one motor result item out.
// Throughput: one item per cycle; the back pipeline holds only while the result queue is full.
// Reset: arm threshold returns to 1500, both queues empty, pipeline stages invalid.
// Depends on qmm_pkg, qmm_fifo, qmm_front, qmm_base_div, qmm_scale_div.
`include "quad_motor_mixer_unit_defines.svh"
module quad_motor_mixer_unit #(
    parameter int unsigned MID_DEPTH = 4,
    parameter int unsigned OUT_DEPTH = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              i_cfg_we,
    input  logic [qmm_pkg::SW_W-1:0]          i_cfg_wdata,
    input  logic [qmm_pkg::THR_W-1:0]         i_throttle,
    input  logic signed [qmm_pkg::GAIN_W-1:0] i_roll,
    input  logic signed [qmm_pkg::GAIN_W-1:0] i_pitch,
    input  logic signed [qmm_pkg::GAIN_W-1:0] i_yaw,
    input  logic [qmm_pkg::DVS_W-1:0]         i_tilt_correction,
    input  logic [qmm_pkg::SW_W-1:0]          i_arm_switch,
    output logic                              empty,
    input  logic                              pop,
    output logic [qmm_pkg::MOTOR_W-1:0]       o_motor_a,
    output logic [qmm_pkg::MOTOR_W-1:0]       o_motor_b,
    output logic [qmm_pkg::MOTOR_W-1:0]       o_motor_c,
    output logic [qmm_pkg::MOTOR_W-1:0]       o_motor_d,
    output logic                              o_armed,
    output logic                              o_leds_on,
    output logic                              o_scaled
);
    import qmm_pkg::*;

    logic      front_wr;
    t_mid_item front_item;
    t_mid_item mid_item;
    logic      mid_full;
    logic      mid_empty;
    logic      adv;
    logic      bd_valid;
    t_mix_item bd_item;
    logic      sd_valid;
    t_res_item sd_item;
    t_res_item res_item;
    logic      out_full;

    assign adv  = ~out_full;
    assign full = mid_full;

    qmm_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .i_full            (mid_full),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_throttle        (i_throttle),
        .i_roll            (i_roll),
        .i_pitch           (i_pitch),
        .i_yaw             (i_yaw),
        .i_tilt_correction (i_tilt_correction),
        .i_arm_switch      (i_arm_switch),
        .o_wr_en           (front_wr),
        .o_item            (front_item)
    );

    qmm_fifo #(
        .WIDTH ($bits(t_mid_item)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (front_wr),
        .i_wr_data (front_item),
        .i_rd_en   (adv),
        .o_rd_data (mid_item),
        .o_full    (mid_full),
        .o_empty   (mid_empty)
    );

    qmm_base_div u_base_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (~mid_empty),
        .i_item  (mid_item),
        .o_valid (bd_valid),
        .o_item  (bd_item)
    );

    qmm_scale_div u_scale_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (bd_valid),
        .i_item  (bd_item),
        .o_valid (sd_valid),
        .o_item  (sd_item)
    );

    qmm_fifo #(
        .WIDTH ($bits(t_res_item)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (sd_valid),
        .i_wr_data (sd_item),
        .i_rd_en   (pop),
        .o_rd_data (res_item),
        .o_full    (out_full),
        .o_empty   (empty)
    );

    assign o_motor_a = res_item.motor_a;
    assign o_motor_b = res_item.motor_b;
    assign o_motor_c = res_item.motor_c;
    assign o_motor_d = res_item.motor_d;
    assign o_armed   = res_item.armed;
    assign o_leds_on = res_item.leds_on;
    assign o_scaled  = res_item.scaled;

    `QMM_ASSERT_IMP(a_idle_when_disarmed, i_clk, i_rst_n, !empty && !o_armed, o_motor_a == MOTOR_IDLE && o_motor_b == MOTOR_IDLE && o_motor_c == MOTOR_IDLE && o_motor_d == MOTOR_IDLE)
    `QMM_ASSERT_IMP(a_leds_need_arm, i_clk, i_rst_n, !empty && o_leds_on, o_armed)
    `QMM_ASSERT_IMP(a_motor_range, i_clk, i_rst_n, !empty, o_motor_a <= MOTOR_MAX && o_motor_b <= MOTOR_MAX && o_motor_c <= MOTOR_MAX && o_motor_d <= MOTOR_MAX)
    `QMM_ASSERT_NXT(a_stall_keeps_result, i_clk, i_rst_n, sd_valid && out_full, sd_valid)

endmodule

FILE: src/qmm_fifo.sv
// Small first-word-fall-through queue in flip-flops.
// Depends on nothing; used between front and back and at the result side.
module qmm_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_go;
    logic             rd_go;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign wr_go     = i_wr_en & ~o_full;
    assign rd_go     = i_rd_en & ~o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (wr_go) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (rd_go) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        unique case ({wr_go, rd_go})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

FILE: src/qmm_front.sv
// Front end: accepts command items, classifies arm state, forms axis products.
// Depends on qmm_pkg; holds the arm threshold register.
module qmm_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    input  logic                                  i_full,
    input  logic                                  i_cfg_we,
    input  logic [qmm_pkg::SW_W-1:0]              i_cfg_wdata,
    input  logic [qmm_pkg::THR_W-1:0]             i_throttle,
    input  logic signed [qmm_pkg::GAIN_W-1:0]     i_roll,
    input  logic signed [qmm_pkg::GAIN_W-1:0]     i_pitch,
    input  logic signed [qmm_pkg::GAIN_W-1:0]     i_yaw,
    input  logic [qmm_pkg::DVS_W-1:0]             i_tilt_correction,
    input  logic [qmm_pkg::SW_W-1:0]              i_arm_switch,
    output logic                                  o_wr_en,
    output qmm_pkg::t_mid_item                    o_item
);
    import qmm_pkg::*;

    logic [SW_W-1:0]          r_arm_threshold;
    logic signed [PROD_W-1:0] thr_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm_threshold <= ARM_THR_RST;
        end else if (i_cfg_we) begin
            r_arm_threshold <= i_cfg_wdata;
        end
    end

    assign o_wr_en = i_push & ~i_full;
    assign thr_s   = PROD_W'($signed({1'b0, i_throttle}));

    always_comb begin
        o_item.throttle   = i_throttle;
        o_item.prod_roll  = thr_s * PROD_W'(i_roll);
        o_item.prod_pitch = thr_s * PROD_W'(i_pitch);
        o_item.prod_yaw   = thr_s * PROD_W'(i_yaw);
        o_item.divisor    = (i_tilt_correction == '0) ? DVS_W'(1) : i_tilt_correction;
        o_item.armed      = (i_arm_switch < r_arm_threshold);
        o_item.leds_on    = (i_arm_switch < r_arm_threshold) && (i_throttle != '0);
    end

endmodule

FILE: src/qmm_base_div.sv
// Back end, first half: axis term truncation and the pipelined base divider.
// Depends on qmm_pkg; one quotient bit per stage, advances on i_adv.
module qmm_base_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  qmm_pkg::t_mid_item i_item,
    output logic               o_valid,
    output qmm_pkg::t_mix_item o_item
);
    import qmm_pkg::*;

    localparam int unsigned STEPS = BASE_W;

    function automatic logic signed [TERM_W-1:0] q14_trunc(
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [PROD_W-1:0] bias;
        logic signed [PROD_W-1:0] adj;
        bias = prod[PROD_W-1] ? PROD_W'(2**Q_FRAC - 1) : '0;
        adj  = prod + bias;
        return TERM_W'(adj >>> Q_FRAC);
    endfunction

    logic              r_vld [0:STEPS];
    logic [BASE_W-1:0] r_num [0:STEPS];
    logic [BASE_W-1:0] n_num [0:STEPS];
    logic [DVS_W-1:0]  r_rem [0:STEPS];
    logic [DVS_W-1:0]  n_rem [0:STEPS];
    logic [DVS_W-1:0]  r_dvs [0:STEPS];
    logic [DVS_W-1:0]  n_dvs [0:STEPS];
    t_side             r_side [0:STEPS];
    t_side             n_side [0:STEPS];
    logic [DVS_W:0]    trial [STEPS];
    logic [DVS_W:0]    diff  [STEPS];
    logic              ge    [STEPS];

    always_comb begin
        n_num[0]             = {i_item.throttle, {Q_FRAC{1'b0}}};
        n_rem[0]             = '0;
        n_dvs[0]             = i_item.divisor;
        n_side[0].term_roll  = q14_trunc(i_item.prod_roll);
        n_side[0].term_pitch = q14_trunc(i_item.prod_pitch);
        n_side[0].term_yaw   = q14_trunc(i_item.prod_yaw);
        n_side[0].armed      = i_item.armed;
        n_side[0].leds_on    = i_item.leds_on;
        for (int s = 0; s < STEPS; s++) begin
            trial[s]    = {r_rem[s], r_num[s][BASE_W-1]};
            diff[s]     = trial[s] - {1'b0, r_dvs[s]};
            ge[s]       = (trial[s] >= {1'b0, r_dvs[s]});
            n_rem[s+1]  = ge[s] ? diff[s][DVS_W-1:0] : trial[s][DVS_W-1:0];
            n_num[s+1]  = {r_num[s][BASE_W-2:0], ge[s]};
            n_dvs[s+1]  = r_dvs[s];
            n_side[s+1] = r_side[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= STEPS; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_adv) begin
            r_vld[0] <= i_valid;
            for (int s = 0; s < STEPS; s++) begin
                r_vld[s+1] <= r_vld[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_num  <= n_num;
            r_rem  <= n_rem;
            r_dvs  <= n_dvs;
            r_side <= n_side;
        end
    end

    assign o_valid     = r_vld[STEPS];
    assign o_item.base = r_num[STEPS];
    assign o_item.side = r_side[STEPS];

endmodule

FILE: src/qmm_scale_div.sv
// Back end, second half: motor mix, peak search, ceiling scaling and drive.
// Depends on qmm_pkg; four restoring divider lanes, advances on i_adv.
module qmm_scale_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  qmm_pkg::t_mix_item i_item,
    output logic               o_valid,
    output qmm_pkg::t_res_item o_item
);
    import qmm_pkg::*;

    localparam int unsigned DW = MAG_W + SQ_W;

    // mix stage
    logic              r_m_vld;
    logic signed [CMD_W-1:0] r_m_cmd [NUM_MOTORS];
    logic signed [CMD_W-1:0] n_m_cmd [NUM_MOTORS];
    logic              r_m_arm, r_m_led;
    // first peak stage
    logic              r_x_vld;
    logic signed [CMD_W-1:0] r_x_cmd [NUM_MOTORS];
    logic signed [CMD_W-1:0] r_x_m01, r_x_m23, n_x_m01, n_x_m23;
    logic              r_x_arm, r_x_led;
    // second peak stage
    logic              r_y_vld;
    logic signed [CMD_W-1:0] r_y_cmd [NUM_MOTORS];
    logic signed [CMD_W-1:0] y_top;
    logic [MAG_W-1:0]  r_y_mx, n_y_mx;
    logic              r_y_arm, r_y_led;
    // divider stages
    logic              r_d_vld [0:SQ_W];
    logic [SDIV_W-1:0] r_d_rem [0:SQ_W][NUM_MOTORS];
    logic [SDIV_W-1:0] n_d_rem [0:SQ_W][NUM_MOTORS];
    logic [SQ_W-1:0]   r_d_q   [0:SQ_W][NUM_MOTORS];
    logic [SQ_W-1:0]   n_d_q   [0:SQ_W][NUM_MOTORS];
    logic [SQ_W-1:0]   r_d_mag [0:SQ_W][NUM_MOTORS];
    logic [SQ_W-1:0]   n_d_mag [0:SQ_W][NUM_MOTORS];
    logic              r_d_neg [0:SQ_W][NUM_MOTORS];
    logic              n_d_neg [0:SQ_W][NUM_MOTORS];
    logic [MAG_W-1:0]  r_d_mx  [0:SQ_W];
    logic [MAG_W-1:0]  n_d_mx  [0:SQ_W];
    logic              r_d_scl [0:SQ_W];
    logic              n_d_scl [0:SQ_W];
    logic              r_d_arm [0:SQ_W];
    logic              n_d_arm [0:SQ_W];
    logic              r_d_led [0:SQ_W];
    logic              n_d_led [0:SQ_W];
    logic [MAG_W-1:0]  mag     [NUM_MOTORS];
    logic [DW-1:0]     dsh     [SQ_W];
    logic [DW-1:0]     rext    [SQ_W][NUM_MOTORS];
    logic              ge      [SQ_W][NUM_MOTORS];
    logic [SQ_W-1:0]   sel     [NUM_MOTORS];
    logic [SQ_W-1:0]   lim     [NUM_MOTORS];
    logic [MOTOR_W-1:0] drive  [NUM_MOTORS];
    logic signed [CMD_W-1:0] b_s, t_r, t_p, t_y;

    always_comb begin
        b_s = $signed({2'b00, i_item.base});
        t_r = CMD_W'(i_item.side.term_roll);
        t_p = CMD_W'(i_item.side.term_pitch);
        t_y = CMD_W'(i_item.side.term_yaw);
        n_m_cmd[0] = b_s - t_r + t_p + t_y;
        n_m_cmd[1] = b_s - t_r - t_p - t_y;
        n_m_cmd[2] = b_s + t_r + t_p - t_y;
        n_m_cmd[3] = b_s + t_r - t_p + t_y;

        n_x_m01 = (r_m_cmd[0] > r_m_cmd[1]) ? r_m_cmd[0] : r_m_cmd[1];
        n_x_m23 = (r_m_cmd[2] > r_m_cmd[3]) ? r_m_cmd[2] : r_m_cmd[3];

        y_top  = (r_x_m01 > r_x_m23) ? r_x_m01 : r_x_m23;
        n_y_mx = y_top[CMD_W-1] ? '0 : MAG_W'(y_top);

        // prepare dividend |cmd| * 1000 for each lane
        n_d_mx[0]  = r_y_mx;
        n_d_scl[0] = (r_y_mx > MAG_W'(CMD_CEIL));
        n_d_arm[0] = r_y_arm;
        n_d_led[0] = r_y_led;
        for (int m = 0; m < NUM_MOTORS; m++) begin
            n_d_neg[0][m] = r_y_cmd[m][CMD_W-1];
            mag[m]        = r_y_cmd[m][CMD_W-1] ? MAG_W'(-r_y_cmd[m]) : MAG_W'(r_y_cmd[m]);
            n_d_rem[0][m] = SDIV_W'(mag[m]) * SDIV_W'(CMD_CEIL);
            n_d_q[0][m]   = '0;
            n_d_mag[0][m] = mag[m][SQ_W-1:0];
        end

        for (int s = 0; s < SQ_W; s++) begin
            dsh[s]       = DW'(r_d_mx[s]) << (SQ_W - 1 - s);
            n_d_mx[s+1]  = r_d_mx[s];
            n_d_scl[s+1] = r_d_scl[s];
            n_d_arm[s+1] = r_d_arm[s];
            n_d_led[s+1] = r_d_led[s];
            for (int m = 0; m < NUM_MOTORS; m++) begin
                rext[s][m]      = DW'(r_d_rem[s][m]);
                ge[s][m]        = (rext[s][m] >= dsh[s]);
                n_d_rem[s+1][m] = ge[s][m] ? SDIV_W'(rext[s][m] - dsh[s]) : r_d_rem[s][m];
                n_d_q[s+1][m]   = {r_d_q[s][m][SQ_W-2:0], ge[s][m]};
                n_d_mag[s+1][m] = r_d_mag[s][m];
                n_d_neg[s+1][m] = r_d_neg[s][m];
            end
        end

        for (int m = 0; m < NUM_MOTORS; m++) begin
            sel[m] = r_d_scl[SQ_W] ? r_d_q[SQ_W][m] : r_d_mag[SQ_W][m];
            lim[m] = (sel[m] > SQ_W'(CMD_CEIL)) ? SQ_W'(CMD_CEIL) : sel[m];
            if (!r_d_arm[SQ_W]) begin
                drive[m] = MOTOR_IDLE;
            end else if (r_d_neg[SQ_W][m]) begin
                drive[m] = MOTOR_IDLE - MOTOR_W'(lim[m]);
            end else begin
                drive[m] = MOTOR_IDLE + MOTOR_W'(sel[m]);
            end
        end

        o_item.motor_a = drive[0];
        o_item.motor_b = drive[1];
        o_item.motor_c = drive[2];
        o_item.motor_d = drive[3];
        o_item.armed   = r_d_arm[SQ_W];
        o_item.leds_on = r_d_led[SQ_W];
        o_item.scaled  = r_d_scl[SQ_W];
    end

    assign o_valid = r_d_vld[SQ_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_x_vld <= 1'b0;
            r_y_vld <= 1'b0;
            for (int s = 0; s <= SQ_W; s++) begin
                r_d_vld[s] <= 1'b0;
            end
        end else if (i_adv) begin
            r_m_vld    <= i_valid;
            r_x_vld    <= r_m_vld;
            r_y_vld    <= r_x_vld;
            r_d_vld[0] <= r_y_vld;
            for (int s = 0; s < SQ_W; s++) begin
                r_d_vld[s+1] <= r_d_vld[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_m_cmd <= n_m_cmd;
            r_m_arm <= i_item.side.armed;
            r_m_led <= i_item.side.leds_on;
            r_x_cmd <= r_m_cmd;
            r_x_m01 <= n_x_m01;
            r_x_m23 <= n_x_m23;
            r_x_arm <= r_m_arm;
            r_x_led <= r_m_led;
            r_y_cmd <= r_x_cmd;
            r_y_mx  <= n_y_mx;
            r_y_arm <= r_x_arm;
            r_y_led <= r_x_led;
            r_d_rem <= n_d_rem;
            r_d_q   <= n_d_q;
            r_d_mag <= n_d_mag;
            r_d_neg <= n_d_neg;
            r_d_mx  <= n_d_mx;
            r_d_scl <= n_d_scl;
            r_d_arm <= n_d_arm;
            r_d_led <= n_d_led;
        end
    end

endmodule
